// ===== rtl/gabc_pkg.sv =====
`default_nettype none

package gabc_pkg;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned ProdW    = 2 * ChanW;
  localparam int unsigned InDataW  = 10 * ChanW;
  localparam int unsigned OutDataW = 3 * ChanW;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned NumStages = 7;

  localparam logic [ChanW-1:0] FillColorReset = 8'd0;
  localparam logic [ChanW-1:0] FillAlphaReset = 8'd255;
  localparam logic [ChanW-1:0] FullScale      = 8'd255;

  typedef enum logic [CfgAddrW-1:0] {
    REG_FILL_RED   = 2'd0,
    REG_FILL_GREEN = 2'd1,
    REG_FILL_BLUE  = 2'd2,
    REG_FILL_ALPHA = 2'd3
  } cfg_reg_t;

  // Load strobes and the zero-coverage flag handed to each channel slice.
  typedef struct packed {
    logic ld_prod;
    logic ld_out;
    logic skip;
  } chan_ctl_t;

  // (a*(256-f) + b*f + 128) >> 8, never negative and never above 255.
  function automatic logic [ChanW-1:0] lerp8(input logic [ChanW-1:0] a,
                                             input logic [ChanW-1:0] b,
                                             input logic [ChanW-1:0] f);
    logic [ChanW:0]   inv_f;
    logic [ProdW:0]   acc;
    inv_f = 9'd256 - {1'b0, f};
    acc   = {9'd0, a} * {8'd0, inv_f} + {9'd0, b} * {9'd0, f} + 17'd128;
    return acc[ProdW-1:ChanW];
  endfunction

  // Rounded divide by 255 for a product of two 8-bit values. The sum with
  // its own high byte plus one, shifted by eight, is an exact floor divide
  // by 255 over the whole range reached here.
  function automatic logic [ChanW-1:0] rdiv255(input logic [ProdW-1:0] x);
    logic [ProdW:0] t;
    logic [ProdW:0] q;
    t = {1'b0, x} + 17'd127;
    q = t + {8'd0, t[ProdW:ChanW]} + 17'd1;
    return q[ProdW-1:ChanW];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gabc_chan.sv =====
`default_nettype none

module gabc_chan (
  input  wire logic                       clk,
  input  wire gabc_pkg::chan_ctl_t        ctl,
  input  wire logic [gabc_pkg::ChanW-1:0] fill_c,
  input  wire logic [gabc_pkg::ChanW-1:0] sa,
  input  wire logic [gabc_pkg::ChanW-1:0] dst,
  output logic      [gabc_pkg::ChanW-1:0] out_c
);

  logic [gabc_pkg::ProdW-1:0] prod_src;
  logic [gabc_pkg::ProdW-1:0] prod_dst;
  logic [gabc_pkg::ChanW-1:0] dst_q;
  logic [gabc_pkg::ChanW-1:0] src_c;
  logic [gabc_pkg::ChanW-1:0] dst_keep;
  logic [gabc_pkg::ChanW:0]   sum;
  logic [gabc_pkg::ChanW-1:0] blended;

  always_ff @(posedge clk) begin
    if (ctl.ld_prod) begin
      prod_src <= {{gabc_pkg::ChanW{1'b0}}, fill_c} * {{gabc_pkg::ChanW{1'b0}}, sa};
      prod_dst <= {{gabc_pkg::ChanW{1'b0}}, dst} *
                  {{gabc_pkg::ChanW{1'b0}}, gabc_pkg::FullScale - sa};
      dst_q    <= dst;
    end
  end

  always_comb begin
    src_c    = gabc_pkg::rdiv255(prod_src);
    dst_keep = gabc_pkg::rdiv255(prod_dst);
    sum      = {1'b0, src_c} + {1'b0, dst_keep};
    blended  = sum[gabc_pkg::ChanW] ? gabc_pkg::FullScale : sum[gabc_pkg::ChanW-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_out) begin
      out_c <= ctl.skip ? dst_q : blended;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/glyph_alpha_bilinear_composite_unit.sv =====
`default_nettype none

// Channel  | Direction | Handshake            | Contents
// s_axis   | in        | tvalid/tready        | one destination pixel with glyph samples
// m_axis   | out       | tvalid/tready        | blended pixel, tuser = written flag
// cfg      | in        | cfg_we, no wait      | fill color and fill alpha registers
//
// Seven register stages: two bilinear lerp steps, coverage product, fill
// alpha product, source alpha divide, color products, divide and blend.
// One pixel is accepted per cycle while the output is not stalled. Each
// stage has its own valid bit and loads when it is empty or the stage after
// it can take its contents, so a stall at the output fills bubbles first.
// Reset (rst, synchronous) empties the pipeline and restores the registers.

module glyph_alpha_bilinear_composite_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [gabc_pkg::CfgAddrW-1:0]   cfg_addr,
  input  wire logic [gabc_pkg::ChanW-1:0]      cfg_wdata,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // dst_red, dst_green, dst_blue, texel_top_left, texel_top_right,
  // texel_bottom_left, texel_bottom_right, frac_x, frac_y, mask_cov
  input  wire logic [gabc_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // out_red, out_green, out_blue
  output logic      [gabc_pkg::OutDataW-1:0]   m_axis_tdata,
  // written
  output logic                                 m_axis_tuser
);

  localparam int unsigned W  = gabc_pkg::ChanW;
  localparam int unsigned PW = gabc_pkg::ProdW;
  localparam int unsigned NS = gabc_pkg::NumStages;

  logic [W-1:0] fill_red;
  logic [W-1:0] fill_green;
  logic [W-1:0] fill_blue;
  logic [W-1:0] fill_alpha;

  logic [NS-1:0] vld;
  logic [NS-1:0] rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_red   <= gabc_pkg::FillColorReset;
      fill_green <= gabc_pkg::FillColorReset;
      fill_blue  <= gabc_pkg::FillColorReset;
      fill_alpha <= gabc_pkg::FillAlphaReset;
    end else if (cfg_we) begin
      unique case (gabc_pkg::cfg_reg_t'(cfg_addr))
        gabc_pkg::REG_FILL_RED:   fill_red   <= cfg_wdata;
        gabc_pkg::REG_FILL_GREEN: fill_green <= cfg_wdata;
        gabc_pkg::REG_FILL_BLUE:  fill_blue  <= cfg_wdata;
        gabc_pkg::REG_FILL_ALPHA: fill_alpha <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or its contents move on this cycle.
  always_comb begin
    rdy[NS-1] = !vld[NS-1] || m_axis_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign s_axis_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  logic [W-1:0] in_tl, in_tr, in_bl, in_br, in_fx, in_fy, in_mk;
  assign in_tl = s_axis_tdata[4*W-1:3*W];
  assign in_tr = s_axis_tdata[5*W-1:4*W];
  assign in_bl = s_axis_tdata[6*W-1:5*W];
  assign in_br = s_axis_tdata[7*W-1:6*W];
  assign in_fx = s_axis_tdata[8*W-1:7*W];
  assign in_fy = s_axis_tdata[9*W-1:8*W];
  assign in_mk = s_axis_tdata[10*W-1:9*W];

  // Stage 0: horizontal lerps on both rows.
  logic [W-1:0]   top0, bot0, fy0, mk0;
  logic [3*W-1:0] dst0;
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      top0 <= gabc_pkg::lerp8(in_tl, in_tr, in_fx);
      bot0 <= gabc_pkg::lerp8(in_bl, in_br, in_fx);
      fy0  <= in_fy;
      mk0  <= in_mk;
      dst0 <= s_axis_tdata[3*W-1:0];
    end
  end

  // Stage 1: vertical lerp.
  logic [W-1:0]   alpha1, mk1;
  logic [3*W-1:0] dst1;
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      alpha1 <= gabc_pkg::lerp8(top0, bot0, fy0);
      mk1    <= mk0;
      dst1   <= dst0;
    end
  end

  // Stage 2: coverage product; zero alpha or zero mask bypasses the blend.
  logic [PW-1:0]  cov2;
  logic           skip2;
  logic [3*W-1:0] dst2;
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      cov2  <= {{W{1'b0}}, alpha1} * {{W{1'b0}}, mk1};
      skip2 <= (alpha1 == '0) || (mk1 == '0);
      dst2  <= dst1;
    end
  end

  // Stage 3: scale by fill alpha.
  logic [PW-1:0]  sa3;
  logic           skip3;
  logic [3*W-1:0] dst3;
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      sa3   <= {{W{1'b0}}, gabc_pkg::rdiv255(cov2)} * {{W{1'b0}}, fill_alpha};
      skip3 <= skip2;
      dst3  <= dst2;
    end
  end

  // Stage 4: premultiplied source alpha.
  logic [W-1:0]   sa4;
  logic           skip4;
  logic [3*W-1:0] dst4;
  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      sa4   <= gabc_pkg::rdiv255(sa3);
      skip4 <= skip3;
      dst4  <= dst3;
    end
  end

  // Stage 5 holds the color products inside the channel slices.
  logic skip5;
  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      skip5 <= skip4;
    end
  end

  // Stage 6: output register.
  logic written6;
  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      written6 <= !skip5;
    end
  end

  gabc_pkg::chan_ctl_t chan_ctl;
  assign chan_ctl.ld_prod = rdy[5];
  assign chan_ctl.ld_out  = rdy[6];
  assign chan_ctl.skip    = skip5;

  gabc_chan u_chan_red (
    .clk    (clk),
    .ctl    (chan_ctl),
    .fill_c (fill_red),
    .sa     (sa4),
    .dst    (dst4[W-1:0]),
    .out_c  (m_axis_tdata[W-1:0])
  );

  gabc_chan u_chan_green (
    .clk    (clk),
    .ctl    (chan_ctl),
    .fill_c (fill_green),
    .sa     (sa4),
    .dst    (dst4[2*W-1:W]),
    .out_c  (m_axis_tdata[2*W-1:W])
  );

  gabc_chan u_chan_blue (
    .clk    (clk),
    .ctl    (chan_ctl),
    .fill_c (fill_blue),
    .sa     (sa4),
    .dst    (dst4[3*W-1:2*W]),
    .out_c  (m_axis_tdata[3*W-1:2*W])
  );

  assign m_axis_tvalid = vld[NS-1];
  assign m_axis_tuser  = written6;

`ifndef ASSERT_OFF
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> vld[0])
    else $error("accepted request did not enter the first stage");

  a_stall_keeps_tail: assert property (@(posedge clk) disable iff (rst)
    (vld[NS-2] && vld[NS-1] && !m_axis_tready) |=> (vld[NS-2] && vld[NS-1]))
    else $error("stalled pipeline tail lost an item");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> (vld == '0))
    else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire
